// File: hw/rtl/mcts_pkg.sv
package mcts_pkg;

  // Field widths
  localparam int CLOSE_W    = 32;
  localparam int VOL_W      = 40;
  localparam int LINE_W     = 48;
  localparam int ALPHA_W    = 16;
  localparam int WIN_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Any EMA difference fits here: fast/slow EMAs stay within the close range,
  // the signal EMA within the MACD range.
  localparam int DIFF_W = 34;

  // Stream data widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 104;

  // Config reset values
  localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST   = 16'd14564;
  localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RST   = 16'd5243;
  localparam logic [ALPHA_W-1:0] SIGNAL_ALPHA_RST = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_ALPHA,
    CFG_SLOW_ALPHA,
    CFG_SIGNAL_ALPHA,
    CFG_BELOW_ZERO,
    CFG_RISING,
    CFG_VOL_WINDOW,
    CFG_EXIT_MODE
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_BUY   = 2'd1,
    ACT_SELL  = 2'd2,
    ACT_CLOSE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_SEED,
    KIND_TRADE,
    KIND_LAST
  } kind_e;

  typedef enum logic {
    EXIT_CROSS,
    EXIT_ZERO
  } exit_e;

  typedef struct packed {
    logic [ALPHA_W-1:0] fast_alpha;
    logic [ALPHA_W-1:0] slow_alpha;
    logic [ALPHA_W-1:0] signal_alpha;
    logic               below_zero_only;
    logic               rising_required;
    logic [WIN_W-1:0]   volume_window;
    exit_e              exit_mode;
  } cfg_t;

  // Classified bar handed from front to back
  typedef struct packed {
    logic [CLOSE_W-1:0] close;
    logic [VOL_W-1:0]   vol;
    kind_e              kind;
    logic               sig_seed;   // second bar: signal takes the MACD value
    logic               rise_chk;   // third bar on: rising filter applies
    logic               surge_chk;  // enough history for the volume test
  } item_t;

  typedef struct packed {
    logic               in_position;
    action_e            action;
    logic signed [LINE_W-1:0] signal_line;
    logic signed [LINE_W-1:0] macd_line;
  } result_t;

endpackage

// File: hw/rtl/mcts_front.sv
module mcts_front #(
  parameter int MAX_VOL_WINDOW = 8,
  parameter int WW             = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [31:0]              close_i,
  input  logic [39:0]              vol_i,
  input  logic                     first_i,
  input  logic                     last_i,
  input  logic [WW-1:0]            win_i,
  output mcts_pkg::item_t          item_o,
  output logic                     item_valid_o,
  input  logic                     item_ready_i
);
  import mcts_pkg::*;

  localparam int BW = $clog2(MAX_VOL_WINDOW + 2);
  localparam logic [BW-1:0] IDX_MAX = BW'(MAX_VOL_WINDOW + 1);

  logic [BW-1:0] bar_idx_q, bar_idx_d;
  logic [BW-1:0] idx;
  logic          seed;
  logic          accept;

  assign in_ready_o   = item_ready_i;
  assign item_valid_o = in_valid_i;
  assign accept       = in_valid_i && item_ready_i;

  // Classify the bar against the series position
  assign seed = first_i || (bar_idx_q == '0);
  assign idx  = seed ? '0 : bar_idx_q;

  always_comb begin
    item_o.close     = close_i;
    item_o.vol       = vol_i;
    item_o.kind      = seed ? KIND_SEED : (last_i ? KIND_LAST : KIND_TRADE);
    item_o.sig_seed  = (idx == BW'(1));
    item_o.rise_chk  = (idx >= BW'(2));
    item_o.surge_chk = (win_i != '0) && (idx >= BW'(win_i));
  end

  // Saturating bar counter
  assign bar_idx_d = (idx == IDX_MAX) ? idx : idx + BW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_idx_q <= '0;
    end else if (accept) begin
      bar_idx_q <= bar_idx_d;
    end
  end

endmodule

// File: hw/rtl/mcts_fifo.sv
module mcts_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  // Two-entry queue
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_data_i;
  end

endmodule

// File: hw/rtl/mcts_back.sv
module mcts_back #(
  parameter int MAX_VOL_WINDOW = 8,
  parameter int ALPHA_BITS     = 16,
  parameter int WW             = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcts_pkg::cfg_t      cfg_i,
  input  logic [WW-1:0]       win_i,
  input  mcts_pkg::item_t     item_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  output mcts_pkg::result_t   res_o,
  output logic                res_valid_o,
  input  logic                res_ready_i
);
  import mcts_pkg::*;

  localparam int AW   = ALPHA_BITS + 1;
  localparam int PRW  = DIFF_W + AW + 1;
  localparam int PW   = (MAX_VOL_WINDOW > 1) ? $clog2(MAX_VOL_WINDOW) : 1;
  localparam int SUMW = VOL_W + WW;
  localparam int CMPW = SUMW + 3;
  localparam logic signed [PRW-1:0] HALF = PRW'(1) << (ALPHA_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FAST,
    S_SLOW,
    S_MACD,
    S_SIG,
    S_DONE
  } state_e;

  // Weight clamped to one
  function automatic logic [AW-1:0] clamp_alpha(logic [ALPHA_W-1:0] a);
    logic [24:0] ax;
    logic [24:0] one;
    ax  = 25'(a);
    one = 25'(1) << ALPHA_BITS;
    return (ax > one) ? one[AW-1:0] : ax[AW-1:0];
  endfunction

  // Rounded EMA increment; arithmetic shift gives round half up
  function automatic logic signed [LINE_W-1:0] ema_inc(logic signed [PRW-1:0] p);
    logic signed [PRW-1:0] t;
    t = (p + HALF) >>> ALPHA_BITS;
    return LINE_W'(t);
  endfunction

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(MAX_VOL_WINDOW - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(logic [PW-1:0] p);
    return (p == '0) ? PW'(MAX_VOL_WINDOW - 1) : p - PW'(1);
  endfunction

  state_e state_q;
  item_t  item_q;

  // Architectural state
  logic signed [LINE_W-1:0] fast_q, slow_q, sig_q, prev_q;
  logic                     holding_q;
  logic [PW-1:0]            ptr_q;

  // Datapath registers
  logic signed [LINE_W-1:0] fast_n_q, slow_n_q, macd_q;
  logic signed [PRW-1:0]    prod_q;
  logic [CMPW-1:0]          vol5w_q;

  // Volume ring and window sum
  logic [VOL_W-1:0] ring_q [MAX_VOL_WINDOW];
  logic [VOL_W-1:0] rd_data_q;
  logic [PW-1:0]    rd_addr_q;
  logic [WW-1:0]    rd_cnt_q;
  logic             rd_pend_q;
  logic [SUMW-1:0]  sum_q;
  logic             sum_busy;

  result_t res_q;
  logic    res_valid_q;

  logic [AW-1:0]            a_fast, a_slow, a_sig, mul_b;
  logic signed [LINE_W-1:0] close_s;
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [PRW-1:0]    prod_d;
  logic [WW+2:0]            w5;
  logic [CMPW-1:0]          sum6;

  logic                     done_fire, pop;
  logic signed [LINE_W-1:0] sig_new, fast_d, slow_d, macd_d, sig_d;
  logic                     hold_d, golden, buy_ok, sell;
  action_e                  act_d;
  logic [PW-1:0]            wr_addr, ptr_d, ptr_eff;

  assign a_fast  = clamp_alpha(cfg_i.fast_alpha);
  assign a_slow  = clamp_alpha(cfg_i.slow_alpha);
  assign a_sig   = clamp_alpha(cfg_i.signal_alpha);
  assign close_s = $signed({{(LINE_W-CLOSE_W){1'b0}}, item_q.close});

  // Shared multiplier operand select
  always_comb begin
    case (state_q)
      S_FAST: begin
        mul_a = DIFF_W'(close_s - fast_q);
        mul_b = a_fast;
      end
      S_SLOW: begin
        mul_a = DIFF_W'(close_s - slow_q);
        mul_b = a_slow;
      end
      default: begin
        mul_a = DIFF_W'(macd_q - sig_q);
        mul_b = a_sig;
      end
    endcase
  end
  assign prod_d = mul_a * $signed({1'b0, mul_b});

  assign w5   = ((WW+3)'(win_i) << 2) + (WW+3)'(win_i);
  assign sum6 = (CMPW'(sum_q) << 2) + (CMPW'(sum_q) << 1);

  assign sum_busy     = (rd_cnt_q != '0) || rd_pend_q;
  assign done_fire    = (state_q == S_DONE) && !sum_busy && (!res_valid_q || res_ready_i);
  assign item_ready_o = (state_q == S_IDLE) || done_fire;
  assign pop          = item_valid_i && item_ready_o;

  // Decision for the bar in flight
  assign sig_new = item_q.sig_seed ? macd_q : sig_q + ema_inc(prod_q);
  assign golden  = (prev_q <= sig_q) && (macd_q > sig_new);

  always_comb begin
    buy_ok = golden;
    if (cfg_i.below_zero_only && (macd_q >= 48'sd0)) buy_ok = 1'b0;
    if (cfg_i.rising_required && item_q.rise_chk && (macd_q <= prev_q)) buy_ok = 1'b0;
    if (item_q.surge_chk && (vol5w_q < sum6)) buy_ok = 1'b0;
    if (cfg_i.exit_mode == EXIT_CROSS) begin
      sell = (prev_q >= sig_q) && (macd_q < sig_new);
    end else begin
      sell = (prev_q >= 48'sd0) && (macd_q < 48'sd0);
    end
  end

  always_comb begin
    fast_d  = fast_n_q;
    slow_d  = slow_n_q;
    macd_d  = macd_q;
    sig_d   = sig_new;
    hold_d  = holding_q;
    act_d   = ACT_NONE;
    wr_addr = ptr_q;
    case (item_q.kind)
      KIND_SEED: begin
        fast_d  = close_s;
        slow_d  = close_s;
        macd_d  = '0;
        sig_d   = '0;
        hold_d  = 1'b0;
        wr_addr = '0;
      end
      KIND_LAST: begin
        if (holding_q) begin
          act_d  = ACT_CLOSE;
          hold_d = 1'b0;
        end
      end
      KIND_TRADE: begin
        if (!holding_q) begin
          if (buy_ok) begin
            act_d  = ACT_BUY;
            hold_d = 1'b1;
          end
        end else if (sell) begin
          act_d  = ACT_SELL;
          hold_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign ptr_d   = ptr_inc(wr_addr);
  assign ptr_eff = done_fire ? ptr_d : ptr_q;

  // Sequencer, architectural state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fast_q      <= '0;
      slow_q      <= '0;
      sig_q       <= '0;
      prev_q      <= '0;
      holding_q   <= 1'b0;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE:  if (pop) state_q <= S_FAST;
        S_FAST:  state_q <= S_SLOW;
        S_SLOW:  state_q <= S_MACD;
        S_MACD:  state_q <= S_SIG;
        S_SIG:   state_q <= S_DONE;
        S_DONE:  if (done_fire) state_q <= pop ? S_FAST : S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      if (done_fire) begin
        fast_q            <= fast_d;
        slow_q            <= slow_d;
        sig_q             <= sig_d;
        prev_q            <= macd_d;
        holding_q         <= hold_d;
        ptr_q             <= ptr_d;
        res_valid_q       <= 1'b1;
        res_q.macd_line   <= macd_d;
        res_q.signal_line <= sig_d;
        res_q.action      <= act_d;
        res_q.in_position <= hold_d;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Window sum control: one ring read per cycle, newest entry first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q  <= '0;
      rd_pend_q <= 1'b0;
    end else if (pop) begin
      rd_cnt_q  <= item_i.surge_chk ? win_i : '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= (rd_cnt_q != '0);
      if (rd_cnt_q != '0) rd_cnt_q <= rd_cnt_q - WW'(1);
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (pop) begin
      item_q    <= item_i;
      rd_addr_q <= ptr_dec(ptr_eff);
      sum_q     <= '0;
    end else begin
      if (rd_cnt_q != '0) rd_addr_q <= ptr_dec(rd_addr_q);
      if (rd_pend_q)      sum_q     <= sum_q + SUMW'(rd_data_q);
    end
    if (state_q == S_FAST || state_q == S_SLOW || state_q == S_SIG) prod_q <= prod_d;
    if (state_q == S_FAST) vol5w_q  <= CMPW'(CMPW'(item_q.vol) * CMPW'(w5));
    if (state_q == S_SLOW) fast_n_q <= fast_q + ema_inc(prod_q);
    if (state_q == S_MACD) begin
      slow_n_q <= slow_q + ema_inc(prod_q);
      macd_q   <= fast_n_q - (slow_q + ema_inc(prod_q));
    end
  end

  // Volume ring
  always_ff @(posedge clk_i) begin
    if (done_fire) ring_q[wr_addr] <= item_q.vol;
    rd_data_q <= ring_q[rd_addr_q];
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

// File: hw/rtl/macd_crossover_trade_signal.sv
// Each item goes through the fast, slow, MACD and signal steps in turn, the three EMA steps
// sharing one multiplier, while the volume window is summed with one ring read per cycle;
// the back end takes a new item only as it finishes the one before.
// A two-entry queue lets the input side run ahead while a result waits.
// Reset (rst_ni low, async): control, EMA state and config registers cleared
// to defaults; the volume ring is not cleared.
module macd_crossover_trade_signal #(
  parameter int MAX_VOL_WINDOW = 8,
  parameter int ALPHA_BITS     = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave side
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mcts_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // close_price, bar_volume
  input  logic                               s_axis_tuser,  // first_bar
  input  logic                               s_axis_tlast,  // last_bar
  // master side
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [mcts_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // macd_line, signal_line,
                                                            // action, in_position
  // config write port
  input  logic                               cfg_we_i,
  input  logic [mcts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mcts_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import mcts_pkg::*;

  localparam int WW = $clog2(MAX_VOL_WINDOW + 1);

  cfg_t          cfg_q;
  logic [WW-1:0] win;
  item_t         f_item, q_item;
  logic          f_valid, f_ready, q_valid, q_ready;
  result_t       res;
  logic          res_valid;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_alpha      <= FAST_ALPHA_RST;
      cfg_q.slow_alpha      <= SLOW_ALPHA_RST;
      cfg_q.signal_alpha    <= SIGNAL_ALPHA_RST;
      cfg_q.below_zero_only <= 1'b0;
      cfg_q.rising_required <= 1'b0;
      cfg_q.volume_window   <= '0;
      cfg_q.exit_mode       <= EXIT_CROSS;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FAST_ALPHA:   cfg_q.fast_alpha      <= cfg_wdata_i;
        CFG_SLOW_ALPHA:   cfg_q.slow_alpha      <= cfg_wdata_i;
        CFG_SIGNAL_ALPHA: cfg_q.signal_alpha    <= cfg_wdata_i;
        CFG_BELOW_ZERO:   cfg_q.below_zero_only <= cfg_wdata_i[0];
        CFG_RISING:       cfg_q.rising_required <= cfg_wdata_i[0];
        CFG_VOL_WINDOW:   cfg_q.volume_window   <= cfg_wdata_i[WIN_W-1:0];
        CFG_EXIT_MODE:    cfg_q.exit_mode       <= exit_e'(cfg_wdata_i[0]);
        default: ;
      endcase
    end
  end

  // Window limited to the ring depth
  assign win = (8'(cfg_q.volume_window) > 8'(MAX_VOL_WINDOW)) ?
               WW'(MAX_VOL_WINDOW) : WW'(cfg_q.volume_window);

  mcts_front #(
    .MAX_VOL_WINDOW(MAX_VOL_WINDOW),
    .WW            (WW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .close_i     (s_axis_tdata[CLOSE_W-1:0]),
    .vol_i       (s_axis_tdata[CLOSE_W+VOL_W-1:CLOSE_W]),
    .first_i     (s_axis_tuser),
    .last_i      (s_axis_tlast),
    .win_i       (win),
    .item_o      (f_item),
    .item_valid_o(f_valid),
    .item_ready_i(f_ready)
  );

  mcts_fifo #(
    .WIDTH($bits(item_t))
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .in_data_i  (f_item),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .out_data_o (q_item)
  );

  mcts_back #(
    .MAX_VOL_WINDOW(MAX_VOL_WINDOW),
    .ALPHA_BITS    (ALPHA_BITS),
    .WW            (WW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .win_i       (win),
    .item_i      (q_item),
    .item_valid_i(q_valid),
    .item_ready_o(q_ready),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = OUT_DATA_W'(res);

  // A buy always leaves the position open
  a_buy_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.action == ACT_BUY) |-> res.in_position)
    else $error("buy without position");

  // A sell or forced close always leaves the position flat
  a_exit_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && (res.action == ACT_SELL || res.action == ACT_CLOSE)) |-> !res.in_position)
    else $error("exit leaves position open");

  // No result is valid right after reset is released
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

// File: tb/sv/macd_signal_checker.sv
`timescale 1ns / 100ps

module macd_signal_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [mcts_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // close_price, bar_volume
  input  logic                            s_axis_tuser,   // first_bar
  input  logic                            s_axis_tlast,   // last_bar
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [mcts_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // macd_line, signal_line,
                                                          // action, in_position
  input  logic                            cfg_we_i,
  input  logic [mcts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcts_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                              fail_count_o,
  output int                              bars_pending_o
);
  import mcts_pkg::*;

  localparam int HIST_DEPTH = 8;
  localparam int RES_W      = $bits(result_t);

  // Shadow copy of the register file
  logic [ALPHA_W-1:0] fast_wt, slow_wt, sig_wt;
  logic               buy_below_zero, buy_rising;
  logic [WIN_W-1:0]   surge_win;
  exit_e              exit_sel;

  // Indicator state
  longint             fast_avg, slow_avg, sig_avg, last_macd;
  int                 bars_seen;    // saturates at HIST_DEPTH + 1
  logic               long_pos;
  logic [VOL_W-1:0]   vol_hist [HIST_DEPTH];
  int                 hist_wr;

  result_t            bar_results [$];
  int                 errs;

  // One EMA step, rounding half up
  function automatic longint ema_next(longint avg, longint x, logic [ALPHA_W-1:0] wt);
    longint acc;
    acc = (x - avg) * longint'({1'b0, wt}) + (longint'(1) <<< (ALPHA_W - 1));
    return avg + (acc >>> ALPHA_W);
  endfunction

  // Advance the indicator by one bar and return what the block must report
  function automatic result_t score_bar(logic [CLOSE_W-1:0] close, logic [VOL_W-1:0] vol,
                                        logic first, logic last);
    result_t          r;
    longint           px, macd, sig;
    logic [63:0]      wsum;
    logic [WIN_W-1:0] win;
    logic             go, quit;
    action_e          act;
    px   = longint'({32'd0, close});
    win  = (surge_win > HIST_DEPTH) ? WIN_W'(HIST_DEPTH) : surge_win;
    act  = ACT_NONE;
    if (first || bars_seen == 0) begin
      // seed bar
      fast_avg  = px;
      slow_avg  = px;
      macd      = 0;
      sig       = 0;
      long_pos  = 1'b0;
      hist_wr   = 0;
      bars_seen = 0;
    end else begin
      fast_avg = ema_next(fast_avg, px, fast_wt);
      slow_avg = ema_next(slow_avg, px, slow_wt);
      macd     = fast_avg - slow_avg;
      sig      = (bars_seen == 1) ? macd : ema_next(sig_avg, macd, sig_wt);
      if (last) begin
        if (long_pos) begin
          act      = ACT_CLOSE;
          long_pos = 1'b0;
        end
      end else if (!long_pos) begin
        // golden cross, then the optional filters
        go = (last_macd <= sig_avg) && (macd > sig);
        if (go && buy_below_zero && macd >= 0) go = 1'b0;
        if (go && buy_rising && bars_seen >= 2 && macd <= last_macd) go = 1'b0;
        if (go && win > 0 && bars_seen >= win) begin
          wsum = '0;
          for (int k = 1; k <= win; k++)
            wsum += {24'd0, vol_hist[(hist_wr + HIST_DEPTH - k) % HIST_DEPTH]};
          // volume >= 1.2 * mean, without a divide
          if ({24'd0, vol} * 64'd5 * {60'd0, win} < wsum * 64'd6) go = 1'b0;
        end
        if (go) begin
          act      = ACT_BUY;
          long_pos = 1'b1;
        end
      end else begin
        if (exit_sel == EXIT_ZERO) quit = (last_macd >= 0) && (macd < 0);
        else                       quit = (last_macd >= sig_avg) && (macd < sig);
        if (quit) begin
          act      = ACT_SELL;
          long_pos = 1'b0;
        end
      end
    end
    vol_hist[hist_wr] = vol;
    hist_wr   = (hist_wr + 1) % HIST_DEPTH;
    last_macd = macd;
    sig_avg   = sig;
    if (bars_seen < HIST_DEPTH + 1) bars_seen++;
    r.macd_line   = macd[LINE_W-1:0];
    r.signal_line = sig[LINE_W-1:0];
    r.action      = act;
    r.in_position = long_pos;
    return r;
  endfunction

  function automatic int field_bad(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t checker: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Watch config writes and both streams
  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want, got;
    if (!rst_ni) begin
      fast_wt        = FAST_ALPHA_RST;
      slow_wt        = SLOW_ALPHA_RST;
      sig_wt         = SIGNAL_ALPHA_RST;
      buy_below_zero = 1'b0;
      buy_rising     = 1'b0;
      surge_win      = '0;
      exit_sel       = EXIT_CROSS;
      fast_avg       = 0;
      slow_avg       = 0;
      sig_avg        = 0;
      last_macd      = 0;
      bars_seen      = 0;
      long_pos       = 1'b0;
      hist_wr        = 0;
      foreach (vol_hist[k]) vol_hist[k] = '0;
      bar_results.delete();
      errs           = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FAST_ALPHA:   fast_wt        = cfg_wdata_i;
          CFG_SLOW_ALPHA:   slow_wt        = cfg_wdata_i;
          CFG_SIGNAL_ALPHA: sig_wt         = cfg_wdata_i;
          CFG_BELOW_ZERO:   buy_below_zero = cfg_wdata_i[0];
          CFG_RISING:       buy_rising     = cfg_wdata_i[0];
          CFG_VOL_WINDOW:   surge_win      = cfg_wdata_i[WIN_W-1:0];
          CFG_EXIT_MODE:    exit_sel       = exit_e'(cfg_wdata_i[0]);
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready)
        bar_results.insert(bar_results.size(),
                           score_bar(s_axis_tdata[CLOSE_W-1:0],
                                     s_axis_tdata[CLOSE_W+:VOL_W],
                                     s_axis_tuser, s_axis_tlast));

      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[RES_W-1:0];
        if (bar_results.size() == 0) begin
          $display("%0t checker: result with no bar pending, expected none, actual %h",
                   $time, m_axis_tdata);
          errs++;
        end else begin
          want = bar_results.pop_front();
          errs += field_bad("macd_line",   want.macd_line,   got.macd_line);
          errs += field_bad("signal_line", want.signal_line, got.signal_line);
          errs += field_bad("action",      want.action,      got.action);
          errs += field_bad("in_position", want.in_position, got.in_position);
          errs += field_bad("padding",     '0,               m_axis_tdata[OUT_DATA_W-1:RES_W]);
        end
      end
    end
    fail_count_o   <= errs;
    bars_pending_o <= bar_results.size();
  end

endmodule

// File: tb/sv/macd_crossover_trade_signal_tb.sv
`timescale 1ns / 100ps

module macd_crossover_trade_signal_tb;
  import mcts_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 10;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  int                    fail_count;
  int                    bars_pending;
  logic                  idle_en  = 1'b1;
  logic                  hold_off = 1'b0;

  // price walk state for the series generator
  longint                price, trend;
  logic [VOL_W-1:0]      vol_base;

  macd_crossover_trade_signal u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  macd_signal_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fail_count_o   (fail_count),
    .bars_pending_o (bars_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    logic held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off && !held) begin
        held          = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= !idle_en || ($urandom_range(0, 99) >= 38);
    end
  end

  // Ends the run if nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // Offer one bar, return once it is taken
  task automatic send_bar(input logic [CLOSE_W-1:0] close, input logic [VOL_W-1:0] vol,
                          input logic first, input logic last);
    if (idle_en)
      while ($urandom_range(0, 99) < 38) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {vol, close};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait for every pending result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (bars_pending != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [ALPHA_W-1:0] fa, sa, ga, input logic bz, rr,
                            input logic [WIN_W-1:0] vw, input exit_e em);
    write_reg(CFG_FAST_ALPHA, fa);
    write_reg(CFG_SLOW_ALPHA, sa);
    write_reg(CFG_SIGNAL_ALPHA, ga);
    write_reg(CFG_BELOW_ZERO, {15'd0, bz});
    write_reg(CFG_RISING, {15'd0, rr});
    write_reg(CFG_VOL_WINDOW, {12'd0, vw});
    write_reg(CFG_EXIT_MODE, {15'd0, em});
    cfg_we_i <= 1'b0;
  endtask

  // Trending random walk so the lines actually cross; rare raw noise
  task automatic next_price(output logic [CLOSE_W-1:0] close);
    longint delta;
    if ($urandom_range(0, 99) < 4) begin
      close = $urandom;
    end else begin
      if ($urandom_range(0, 99) < 25)
        trend = (longint'($urandom_range(0, 200)) - 100) * ((price >>> 10) + 64);
      delta = (longint'($urandom_range(0, 40)) - 20) * ((price >>> 12) + 16);
      price = price + trend + delta;
      if (price < 0) price = 0;
      if (price > 64'sd4294967295) price = 64'sd4294967295;
      close = price[CLOSE_W-1:0];
    end
  endtask

  // Volumes around the series base, with surges and extremes
  task automatic next_volume(output logic [VOL_W-1:0] vol);
    case ($urandom_range(0, 9))
      0:       vol = {8'($urandom), 32'($urandom)};
      1:       vol = vol_base << 1;
      2:       vol = '0;
      default: vol = vol_base + 40'($urandom_range(0, 400)) * (vol_base >> 10);
    endcase
  endtask

  // Mostly well-formed series (first mark, bars, last mark), some raw noise
  task automatic run_bars(input int count);
    int                 left;
    logic               first, last;
    logic [CLOSE_W-1:0] close;
    logic [VOL_W-1:0]   vol;
    left = 0;
    repeat (count) begin
      if ($urandom_range(0, 99) < 5) begin
        send_bar($urandom, {8'($urandom), 32'($urandom)}, 1'($urandom), 1'($urandom));
      end else begin
        first = 1'b0;
        if (left == 0) begin
          left     = $urandom_range(2, 30);
          first    = ($urandom_range(0, 9) != 0);
          price    = 64'($urandom_range(32'h0010_0000, 32'h4000_0000));
          trend    = 0;
          vol_base = 40'($urandom_range(4096, 32'h4000_0000));
        end
        next_price(close);
        next_volume(vol);
        left--;
        last = (left == 0) && ($urandom_range(0, 3) != 0);
        send_bar(close, vol, first, last);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: seed without a first mark, extremes, crosses, last-bar cases
    send_bar(32'h0001_0000, 40'h0, 1'b0, 1'b0);
    send_bar(32'h0000_0000, 40'hFF_FFFF_FFFF, 1'b0, 1'b0);
    send_bar(32'h0000_0000, 40'h1, 1'b0, 1'b0);
    send_bar(32'h0000_0000, 40'h2, 1'b0, 1'b0);
    send_bar(32'hFFFF_FFFF, 40'h5, 1'b0, 1'b0);
    send_bar(32'hFFFF_FFFF, 40'h5, 1'b0, 1'b0);
    send_bar(32'h0000_0000, 40'h5, 1'b0, 1'b0);
    send_bar(32'h0000_0000, 40'h5, 1'b0, 1'b0);
    send_bar(32'hFFFF_FFFF, 40'h5, 1'b0, 1'b0);
    send_bar(32'h8000_0000, 40'h7, 1'b0, 1'b1);
    send_bar(32'h8000_0000, 40'h7, 1'b0, 1'b0);
    send_bar(32'h1234_5678, 40'hAA_AAAA_AAAA, 1'b1, 1'b1);
    send_bar(32'h0000_FFFF, 40'h55_5555_5555, 1'b0, 1'b1);
    send_bar(32'hFFFF_0000, 40'hFF_FFFF_FFFF, 1'b1, 1'b0);
    send_bar(32'h0000_0001, 40'h0, 1'b0, 1'b0);
    send_bar(32'h0000_0001, 40'h0, 1'b0, 1'b0);
    send_bar(32'hFFFF_FFFF, 40'h0, 1'b0, 1'b0);
    send_bar(32'h0000_0000, 40'h0, 1'b0, 1'b0);
    send_bar(32'hFFFF_FFFF, 40'h3, 1'b0, 1'b1);
    run_bars(40);
    drain();

    for (int ph = 1; ph < PHASES; ph++) begin
      case (ph)
        1: set_config(16'hFFFF, 16'h0001, 16'hFFFF, 1'b0, 1'b0, 4'd8, EXIT_CROSS);
        // frozen averages, every filter on, window past the ring depth
        2: set_config(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 4'd15, EXIT_ZERO);
        3: begin
          set_config(16'd13107, 16'd6000, 16'd20000, 1'b1, 1'b0, 4'd3, EXIT_ZERO);
          idle_en <= 1'b0;
        end
        // long result stall: block must back up into the input side
        4: begin
          set_config(16'd30000, 16'd9000, 16'd40000, 1'b0, 1'b1, 4'd1, EXIT_CROSS);
          idle_en  <= 1'b1;
          hold_off <= 1'b1;
        end
        default: set_config(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                            1'($urandom), 4'($urandom_range(0, 15)),
                            exit_e'($urandom_range(0, 1)));
      endcase
      run_bars(ph == 2 ? 30 : 66);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
